// ----- design/lse_pkg.sv -----
`timescale 1ns / 1ps
package lse_pkg;

  typedef enum logic [2:0] {
    FN_WRITE   = 3'd0,
    FN_READ    = 3'd1,
    FN_SEED    = 3'd2,
    FN_EMBED   = 3'd3,
    FN_EXTRACT = 3'd4,
    FN_HEADER  = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CAPACITY = 2'd1,
    ST_ADDRESS  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_SCATTER = 2'd0,
    REG_LEN     = 2'd1
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_DRAW,
    S_MOD,
    S_VCHK,
    S_PROBE,
    S_PIXRD,
    S_PIXWAIT,
    S_PIXWR,
    S_HDR,
    S_DONE
  } state_t;

  localparam int RETRY_LIMIT = 64;
  localparam logic [31:0] GEN_B_INIT = 32'd7;
  localparam logic [31:0] GEN_C_INIT = 32'd11;
  localparam logic [31:0] GEN_D_INIT = 32'd3;
  localparam logic [16:0] SEQ_START  = 17'd3;

  // one xorshift step: new fourth word before the modulo
  function automatic logic [31:0] xs_next(input logic [31:0] a, input logic [31:0] d);
    logic [31:0] t;
    t = a ^ (a << 11);
    return d ^ (d >> 19) ^ t ^ (t >> 8);
  endfunction

endpackage

// ----- design/lsb_stego_embed_extract.sv -----
`timescale 1ns / 1ps
// LSB steganography embed/extract engine over an on-chip image byte store.
// Input channel in_*: func selects write byte, read byte, seed, embed,
// extract or write header; one result item (out_rdata, out_status) per item.
// Config (cfg_we/cfg_index/cfg_wdata) sets scatter_mode and image_len; write
// only while idle.
// Items are handled one at a time; the next item can be taken in the cycle
// after the result is accepted. A seed result waits for the visited-map sweep.
// Embed/extract, sequential: per bit an address, a read and a write step.
// Embed/extract, scattered: per bit the draw, the bit-serial remainder unit,
// the visited-map read and the pixel read/write; each collision adds another
// draw, remainder and visited-map read, and after 64 collisions a probe
// walks the map entry by entry.
// Reset sweeps the visited map, one entry per cycle;
// no item is accepted meanwhile.
// The result sits in an output register; a stalled receiver holds the block
// in its done state until out_ready.
module lsb_stego_embed_extract
  import lse_pkg::*;
#(
  parameter int IMAGE_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_func,
  input  logic [15:0] in_addr,
  input  logic [7:0]  in_wdata,
  input  logic [31:0] in_seed,
  input  logic [23:0] in_payload_len,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_rdata,
  output logic [1:0]  out_status,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_wdata
);
  localparam int AW = $clog2(IMAGE_BYTES);
  localparam int RW = $clog2(RETRY_LIMIT + 1);

  state_t state_r, state_nxt;
  logic          scatter_r;
  logic [16:0]   ilen_r;
  logic [31:0]   ga_r, gb_r, gc_r, gd_r, ga_nxt, gb_nxt, gc_nxt, gd_nxt;
  logic [16:0]   seq_r, seq_nxt;
  logic [15:0]   done_cnt_r, done_cnt_nxt;
  logic [2:0]    func_r, func_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [7:0]    wd_r, wd_nxt;
  logic [23:0]   plen_r, plen_nxt;
  logic [2:0]    bit_r, bit_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [RW-1:0] tries_r, tries_nxt;
  logic [AW:0]   clr_r, clr_nxt;
  logic [1:0]    hb_r, hb_nxt;
  logic [7:0]    rd_r, rd_nxt;
  logic [1:0]    st_r, st_nxt;

  // effective length, clamped to [16, IMAGE_BYTES]
  logic [AW:0] len;
  always_comb begin
    if ({15'd0, ilen_r} > 32'(IMAGE_BYTES)) len = (AW+1)'(IMAGE_BYTES);
    else if (ilen_r < 17'd16) len = (AW+1)'(16);
    else len = (AW+1)'(ilen_r);
  end
  logic [AW-3:0] cap;
  assign cap = len[AW:3]; // L/8
  logic [AW-2:0] cap_w;
  assign cap_w = {1'b0, len[AW:3]};

  // remainder unit
  logic          mod_start, mod_done;
  logic [AW-1:0] mod_rem;
  lse_mod #(.AW(AW)) u_mod (
    .clk(clk), .rst_n(rst_n), .start(mod_start), .num(gd_r),
    .den(len), .done(mod_done), .rem(mod_rem)
  );

  // memories
  logic          img_we, vis_we, vis_wd, vis_rd;
  logic [AW-1:0] img_addr, vis_addr;
  logic [7:0]    img_wd, img_rd;
  lse_mem #(.AW(AW)) u_mem (
    .clk(clk), .img_we(img_we), .img_addr(img_addr), .img_wdata(img_wd),
    .img_rdata(img_rd), .vis_we(vis_we), .vis_addr(vis_addr),
    .vis_wdata(vis_wd), .vis_rdata(vis_rd)
  );

  logic [2:0] w;
  assign w = scatter_r ? bit_r : 3'd7 - bit_r;

  // sequential position (seq + bit) mod len; seq + bit stays below 2 * len
  // while capacity holds, so one compare reduces it
  logic [17:0] sp;
  logic [AW-1:0] seq_pos;
  always_comb begin
    sp = {1'b0, seq_r} + 18'(bit_r);
    seq_pos = AW'(sp);
    if (sp >= 18'(len)) seq_pos = AW'(sp - 18'(len));
  end

  logic [AW-1:0] probe_nxt_pos;
  assign probe_nxt_pos = ((AW+1)'(pos_r) + 1'b1 == len) ? '0 : pos_r + 1'b1;

  always_comb begin
    state_nxt    = state_r;
    ga_nxt = ga_r; gb_nxt = gb_r; gc_nxt = gc_r; gd_nxt = gd_r;
    seq_nxt      = seq_r;
    done_cnt_nxt = done_cnt_r;
    func_nxt     = func_r;
    addr_nxt     = addr_r;
    wd_nxt       = wd_r;
    plen_nxt     = plen_r;
    bit_nxt      = bit_r;
    pos_nxt      = pos_r;
    tries_nxt    = tries_r;
    clr_nxt      = clr_r;
    hb_nxt       = hb_r;
    rd_nxt       = rd_r;
    st_nxt       = st_r;
    mod_start    = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (AW+1)'(IMAGE_BYTES - 1)) state_nxt = S_DONE;
      end
      S_IDLE: if (in_valid) begin
        func_nxt = in_func; addr_nxt = AW'(in_addr); wd_nxt = in_wdata;
        plen_nxt = in_payload_len;
        rd_nxt = '0; st_nxt = ST_OK; bit_nxt = '0; tries_nxt = '0; hb_nxt = '0;
        state_nxt = S_DONE;
        case (in_func) inside
          FN_WRITE, FN_READ: begin
            if ({1'b0, in_addr} >= 17'(len)) st_nxt = ST_ADDRESS;
            else if (in_func == FN_READ) state_nxt = S_PIXWAIT;
          end
          FN_SEED: begin
            ga_nxt = in_seed; gb_nxt = GEN_B_INIT; gc_nxt = GEN_C_INIT;
            gd_nxt = GEN_D_INIT; seq_nxt = SEQ_START; done_cnt_nxt = '0;
            clr_nxt = '0; state_nxt = S_CLEAR;
          end
          FN_EMBED, FN_EXTRACT: begin
            if (32'(done_cnt_r) >= 32'(cap) - 32'd1) st_nxt = ST_CAPACITY;
            else state_nxt = scatter_r ? S_DRAW : S_PIXRD;
          end
          FN_HEADER: begin
            if (32'(in_payload_len) >= 32'(cap_w)) st_nxt = ST_CAPACITY;
            else state_nxt = S_HDR;
          end
          default: ;
        endcase
      end
      S_DRAW: begin
        ga_nxt = gb_r; gb_nxt = gc_r; gc_nxt = gd_r;
        gd_nxt = xs_next(ga_r, gd_r);
        state_nxt = S_MOD;
      end
      S_MOD: begin
        mod_start = 1'b1;
        state_nxt = S_VCHK;
      end
      S_VCHK: begin
        if (mod_done) begin
          gd_nxt = 32'(mod_rem); pos_nxt = mod_rem; state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        // vis_rd for pos_r is a registered read: it is checked when hb_r is 1
        if (hb_r == 2'd0) hb_nxt = 2'd1;
        else begin
          hb_nxt = '0;
          if (!vis_rd) state_nxt = S_PIXRD;
          else if (32'(tries_r) + 32'd1 >= 32'(RETRY_LIMIT)) begin
            tries_nxt = RW'(RETRY_LIMIT); pos_nxt = probe_nxt_pos;
          end else begin
            tries_nxt = tries_r + 1'b1; state_nxt = S_DRAW;
          end
        end
      end
      S_PIXRD: begin
        if (!scatter_r) pos_nxt = seq_pos;
        state_nxt = S_PIXWAIT;
      end
      S_PIXWAIT: state_nxt = S_PIXWR;
      S_PIXWR: begin
        if (func_r == FN_READ) begin
          rd_nxt = img_rd; state_nxt = S_DONE;
        end else begin
          if (func_r == FN_EXTRACT) rd_nxt = rd_r | (8'(img_rd[0]) << w);
          bit_nxt = bit_r + 1'b1; tries_nxt = '0;
          state_nxt = scatter_r ? S_DRAW : S_PIXRD;
          if (bit_r == 3'd7) begin
            if (!scatter_r) seq_nxt = seq_r + 17'd8;
            done_cnt_nxt = done_cnt_r + 1'b1;
            state_nxt = S_DONE;
          end
        end
      end
      S_HDR: begin
        hb_nxt = hb_r + 1'b1;
        if (hb_r == 2'd2) state_nxt = S_DONE;
      end
      S_DONE: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    img_we = 1'b0; img_addr = pos_r; img_wd = '0;
    vis_we = 1'b0; vis_addr = pos_r; vis_wd = 1'b0;
    unique case (state_r)
      S_CLEAR: begin vis_we = 1'b1; vis_addr = AW'(clr_r); end
      S_IDLE: begin
        img_addr = AW'(in_addr);
        img_wd = in_wdata;
        img_we = in_valid && in_func == FN_WRITE && {1'b0, in_addr} < 17'(len);
      end
      S_PIXWAIT: img_addr = (func_r == FN_READ) ? addr_r : pos_r;
      S_PIXWR: begin
        img_addr = pos_r;
        img_wd = {img_rd[7:1], wd_r[w]};
        img_we = func_r == FN_EMBED;
        vis_we = scatter_r && func_r != FN_READ;
        vis_wd = 1'b1;
      end
      S_HDR: begin
        img_we = 1'b1; img_addr = AW'(hb_r);
        img_wd = (hb_r == 2'd0) ? plen_r[23:16] :
                 (hb_r == 2'd1) ? plen_r[15:8] : plen_r[7:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; clr_r <= '0;
      scatter_r <= 1'b0; ilen_r <= 17'd65536;
      ga_r <= '0; gb_r <= GEN_B_INIT; gc_r <= GEN_C_INIT; gd_r <= GEN_D_INIT;
      seq_r <= SEQ_START; done_cnt_r <= '0;
      func_r <= 3'd7; tries_r <= '0; hb_r <= '0; bit_r <= '0;
    end else begin
      state_r <= (state_r == S_CLEAR && state_nxt == S_DONE && func_r != FN_SEED)
                 ? S_IDLE : state_nxt;
      clr_r <= clr_nxt;
      ga_r <= ga_nxt; gb_r <= gb_nxt; gc_r <= gc_nxt; gd_r <= gd_nxt;
      seq_r <= seq_nxt; done_cnt_r <= done_cnt_nxt;
      func_r <= func_nxt; tries_r <= tries_nxt; hb_r <= hb_nxt; bit_r <= bit_nxt;
      if (cfg_we && cfg_index == REG_SCATTER) scatter_r <= cfg_wdata[0];
      if (cfg_we && cfg_index == REG_LEN) ilen_r <= cfg_wdata;
    end
    addr_r <= addr_nxt; wd_r <= wd_nxt; plen_r <= plen_nxt;
    pos_r <= pos_nxt; rd_r <= rd_nxt; st_r <= st_nxt;
  end

  assign in_ready   = state_r == S_IDLE;
  assign out_valid  = state_r == S_DONE;
  assign out_rdata  = rd_r;
  assign out_status = st_r;

`ifndef SYNTHESIS
  a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready and valid together");
  a_cap_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_rdata == 8'd0)
    else $error("error result with data");
  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rdata))
    else $error("result dropped");
`endif
endmodule

// ----- design/lse_mod.sv -----
`timescale 1ns / 1ps
// Restoring remainder, one quotient bit per cycle.
module lse_mod
  import lse_pkg::*;
#(
  parameter int AW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [31:0]   num,
  input  logic [AW:0]   den,
  output logic          done,
  output logic [AW-1:0] rem
);
  localparam int CW = $clog2(33);
  logic [31:0]   num_r, num_nxt;
  logic [AW+1:0] acc_r, acc_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [AW+1:0] sh;

  always_comb begin
    num_nxt  = num_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sh       = {acc_r[AW:0], num_r[31]};
    if (start) begin
      num_nxt  = num;
      acc_nxt  = '0;
      cnt_nxt  = CW'(32);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[30:0], 1'b0};
      acc_nxt = (sh >= {1'b0, den}) ? sh - {1'b0, den} : sh;
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign rem  = acc_r[AW-1:0];
endmodule

// ----- design/lse_mem.sv -----
`timescale 1ns / 1ps
// Image byte store and visited map, each with a registered read.
module lse_mem #(
  parameter int AW = 16
) (
  input  logic          clk,
  input  logic          img_we,
  input  logic [AW-1:0] img_addr,
  input  logic [7:0]    img_wdata,
  output logic [7:0]    img_rdata,
  input  logic          vis_we,
  input  logic [AW-1:0] vis_addr,
  input  logic          vis_wdata,
  output logic          vis_rdata
);
  logic [7:0] img_mem [2**AW];
  logic       vis_mem [2**AW];

  always_ff @(posedge clk) begin
    if (img_we) img_mem[img_addr] <= img_wdata;
    img_rdata <= img_mem[img_addr];
  end

  always_ff @(posedge clk) begin
    if (vis_we) vis_mem[vis_addr] <= vis_wdata;
    vis_rdata <= vis_mem[vis_addr];
  end
endmodule
